FILE: hdl/bm25_pkg.sv
`timescale 1ns / 1ps

package bm25_pkg;

	localparam int CNT_W       = 24;
	localparam int WT_W        = 32;
	localparam int INV_W       = 32;
	localparam int K1_W        = 24;
	localparam int B_W         = 17;
	localparam int NL_W        = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int COUNT_BITS_DEF = 24;

	// Q.16 one
	localparam logic [B_W-1:0] UNITY = 17'h10000;

	localparam logic [WT_W-1:0]  TERM_WEIGHT_RST = 32'h0001_0000;
	localparam logic [INV_W-1:0] INV_AVG_RST     = 32'h0100_0000;
	localparam logic [K1_W-1:0]  K1_RST          = 24'h01_0000;
	localparam logic [B_W-1:0]   B_RST           = 17'h0_8000;
	localparam logic [NL_W-1:0]  MIN_NL_RST      = 24'h00_8000;
	localparam logic [WT_W-1:0]  EXTRA_NUM_RST   = 32'h0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TERM_WEIGHT = 3'd0,
		REG_INV_AVG     = 3'd1,
		REG_K1          = 3'd2,
		REG_B           = 3'd3,
		REG_MIN_NL      = 3'd4,
		REG_EXTRA_NUM   = 3'd5
	} cfg_reg_t;

endpackage

FILE: hdl/bm25_in_if.sv
`timescale 1ns / 1ps

interface bm25_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [bm25_pkg::CNT_W-1:0]  wdf;
	logic [bm25_pkg::CNT_W-1:0]  doc_len;

	modport source (output valid, output action, output wdf, output doc_len, input ready);
	modport sink   (input valid, input action, input wdf, input doc_len, output ready);
endinterface

FILE: hdl/bm25_out_if.sv
`timescale 1ns / 1ps

interface bm25_out_if;
	logic                        valid;
	logic                        ready;
	logic [bm25_pkg::WT_W-1:0]   part_weight;
	logic [bm25_pkg::WT_W-1:0]   extra_weight;

	modport source (output valid, output part_weight, output extra_weight, input ready);
	modport sink   (input valid, input part_weight, input extra_weight, output ready);
endinterface

FILE: hdl/bm25_document_term_score_top.sv
`timescale 1ns / 1ps

// channel    dir   beat payload                   handshake
// posting    in    action, wdf, doc_len           valid/ready
// score      out   part_weight, extra_weight      valid/ready
// cfg        in    cfg_idx, cfg_data              cfg_we, no back-pressure
//
// One posting per cycle sustained while the skid stage is empty; eight arithmetic
// stages, 32 restoring-division stages at one quotient bit each, output reg.
// arst_n clears valid bits, output/skid state and the registers to defaults.
// The pipeline advances as a whole while the skid stage is empty; a stalled
// output fills the skid, which then drops posting.ready until it drains.

module bm25_document_term_score_top #(
	parameter int COUNT_BITS = bm25_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bm25_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bm25_pkg::CFG_DATA_W-1:0]   cfg_data,
	bm25_in_if.sink                           posting,
	bm25_out_if.source                        score
);

	localparam int CW    = bm25_pkg::CNT_W;
	localparam int MB    = (COUNT_BITS < CW) ? COUNT_BITS : CW;
	localparam logic [CW-1:0] CNT_MASK = CW'((64'(1) << MB) - 64'(1));
	localparam int STEPS = 32;
	localparam int DEN_W = 41;
	localparam int DX_W  = 25;

	// configuration
	logic [31:0] tw_q, inv_q, en_q;
	logic [23:0] k1_q, min_nl_q;
	logic [16:0] b_q, bb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q     <= bm25_pkg::TERM_WEIGHT_RST;
			inv_q    <= bm25_pkg::INV_AVG_RST;
			k1_q     <= bm25_pkg::K1_RST;
			b_q      <= bm25_pkg::B_RST;
			min_nl_q <= bm25_pkg::MIN_NL_RST;
			en_q     <= bm25_pkg::EXTRA_NUM_RST;
		end else if (cfg_we) begin
			case (bm25_pkg::cfg_reg_t'(cfg_idx))
				bm25_pkg::REG_TERM_WEIGHT: tw_q     <= cfg_data;
				bm25_pkg::REG_INV_AVG:     inv_q    <= cfg_data;
				bm25_pkg::REG_K1:          k1_q     <= cfg_data[23:0];
				bm25_pkg::REG_B:           b_q      <= cfg_data[16:0];
				bm25_pkg::REG_MIN_NL:      min_nl_q <= cfg_data[23:0];
				bm25_pkg::REG_EXTRA_NUM:   en_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bb = (b_q > bm25_pkg::UNITY) ? bm25_pkg::UNITY : b_q;

	function automatic logic [23:0] norm_len(input logic [55:0] m, input logic [23:0] lo);
		logic [47:0] n;
		logic [23:0] s;
		n = m[55:8];
		s = (|n[47:24]) ? 24'hFF_FFFF : n[23:0];
		return (s < lo) ? lo : s;
	endfunction

	// output register and skid
	logic adv;
	logic sv_q, ov_q;
	logic [63:0] sd_q, od_q;
	logic vl;
	logic [63:0] dl;

	assign adv = !sv_q;
	assign posting.ready = adv;

	// S1: mask counts, pick length for the term part
	logic v_s1;
	logic [CW-1:0] wdf_s1, len_s1, plen_s1, w_m, l_m;
	assign w_m = posting.wdf & CNT_MASK;
	assign l_m = posting.doc_len & CNT_MASK;

	// S2: products
	logic v_s2;
	logic [55:0] mp_s2, ml_s2, pw_s2;
	logic [CW-1:0] wdf_s2;

	// S3: normalised lengths
	logic v_s3;
	logic [23:0] nlp_s3, nll_s3;
	logic [55:0] pw_s3;
	logic [CW-1:0] wdf_s3;

	// S4: normlen * b
	logic v_s4;
	logic [40:0] ib_s4;
	logic [23:0] nll_s4;
	logic [55:0] pw_s4;
	logic [CW-1:0] wdf_s4;

	// S5: inner
	logic v_s5;
	logic [24:0] inner_s5;
	logic [23:0] nll_s5;
	logic [55:0] pw_s5;
	logic [CW-1:0] wdf_s5;

	// S6: k1 * inner
	logic v_s6;
	logic [48:0] kp_s6;
	logic [23:0] nll_s6;
	logic [55:0] pw_s6;
	logic [CW-1:0] wdf_s6;

	// S7: denominator
	logic v_s7;
	logic [DEN_W-1:0] den_s7;
	logic [23:0] nll_s7;
	logic [55:0] pw_s7;

	// division pipeline; index 0 is the set-up stage
	logic             v_sd    [0:STEPS];
	logic             zero_sd [0:STEPS];
	logic             ovf_sd  [0:STEPS];
	logic [DEN_W-1:0] den_sd  [0:STEPS];
	logic [DEN_W-1:0] prem_sd [0:STEPS];
	logic [31:0]      pq_sd   [0:STEPS];
	logic [DX_W-1:0]  dx_sd   [0:STEPS];
	logic [DX_W-1:0]  erem_sd [0:STEPS];
	logic [31:0]      eq_sd   [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_sd[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= posting.valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_sd[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wdf_s1  <= w_m;
			len_s1  <= l_m;
			plen_s1 <= (posting.action && (w_m > l_m)) ? w_m : l_m;

			mp_s2  <= 56'(plen_s1) * 56'(inv_q);
			ml_s2  <= 56'(len_s1) * 56'(inv_q);
			pw_s2  <= 56'(wdf_s1) * 56'(tw_q);
			wdf_s2 <= wdf_s1;

			nlp_s3 <= norm_len(mp_s2, min_nl_q);
			nll_s3 <= norm_len(ml_s2, min_nl_q);
			pw_s3  <= pw_s2;
			wdf_s3 <= wdf_s2;

			ib_s4  <= 41'(nlp_s3) * 41'(bb);
			nll_s4 <= nll_s3;
			pw_s4  <= pw_s3;
			wdf_s4 <= wdf_s3;

			inner_s5 <= 25'(ib_s4[40:16]) + 25'(17'(bm25_pkg::UNITY - bb));
			nll_s5   <= nll_s4;
			pw_s5    <= pw_s4;
			wdf_s5   <= wdf_s4;

			kp_s6  <= 49'(k1_q) * 49'(inner_s5);
			nll_s6 <= nll_s5;
			pw_s6  <= pw_s5;
			wdf_s6 <= wdf_s5;

			den_s7 <= 41'(kp_s6[48:16]) + 41'({wdf_s6, 16'h0});
			nll_s7 <= nll_s6;
			pw_s7  <= pw_s6;

			// saturate when the quotient needs more than 32 bits
			zero_sd[0] <= (den_s7 == '0);
			ovf_sd[0]  <= (57'(pw_s7) >= {den_s7, 16'h0});
			den_sd[0]  <= den_s7;
			prem_sd[0] <= 41'(pw_s7[55:16]);
			pq_sd[0]   <= {pw_s7[15:0], 16'h0};
			dx_sd[0]   <= 25'(nll_s7) + 25'(bm25_pkg::UNITY);
			erem_sd[0] <= 25'(en_q[31:16]);
			eq_sd[0]   <= {en_q[15:0], 16'h0};
		end
	end

	// one restoring step per stage; the shift register holds dividend low
	// bits on top and collects quotient bits at the bottom
	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic [DEN_W:0]  pr2;
		logic            ptake;
		logic [DX_W:0]   er2;
		logic            etake;

		always_comb begin
			pr2   = {prem_sd[k], pq_sd[k][31]};
			ptake = (pr2 >= {1'b0, den_sd[k]});
			er2   = {erem_sd[k], eq_sd[k][31]};
			etake = (er2 >= {1'b0, dx_sd[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (adv) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_sd[k+1] <= zero_sd[k];
				ovf_sd[k+1]  <= ovf_sd[k];
				den_sd[k+1]  <= den_sd[k];
				dx_sd[k+1]   <= dx_sd[k];
				prem_sd[k+1] <= ptake ? DEN_W'(pr2 - {1'b0, den_sd[k]}) : DEN_W'(pr2);
				pq_sd[k+1]   <= {pq_sd[k][30:0], ptake};
				erem_sd[k+1] <= etake ? DX_W'(er2 - {1'b0, dx_sd[k]}) : DX_W'(er2);
				eq_sd[k+1]   <= {eq_sd[k][30:0], etake};
			end
		end
	end

	assign vl = v_sd[STEPS];
	assign dl[63:32] = zero_sd[STEPS] ? 32'h0 : (ovf_sd[STEPS] ? 32'hFFFF_FFFF : pq_sd[STEPS]);
	assign dl[31:0]  = eq_sd[STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (!ov_q || score.ready) begin
			ov_q <= sv_q || vl;
			sv_q <= 1'b0;
		end else if (vl && !sv_q) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || score.ready) begin
			od_q <= sv_q ? sd_q : dl;
		end else if (vl && !sv_q) begin
			sd_q <= dl;
		end
	end

	assign score.valid        = ov_q;
	assign score.part_weight  = od_q[63:32];
	assign score.extra_weight = od_q[31:0];

	a_skid_implies_out : assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid holds a beat while the output register is empty");

	a_skid_fill : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(ov_q && !score.ready && vl))
		else $error("skid filled without a stalled output");

	a_div_start : assert property (@(posedge clk) disable iff (!arst_n)
		(v_sd[0] && !zero_sd[0] && !ovf_sd[0]) |-> (prem_sd[0] < den_sd[0]))
		else $error("division set-up remainder not below divisor");

	a_extra_start : assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[0] |-> (erem_sd[0] < dx_sd[0]))
		else $error("extra division set-up remainder not below divisor");

endmodule

FILE: dv/bm25_document_term_score_top_test.sv
`timescale 1ns / 1ps

module bm25_document_term_score_top_test;

	typedef struct packed {
		logic [bm25_pkg::WT_W-1:0] part_weight;
		logic [bm25_pkg::WT_W-1:0] extra_weight;
	} score_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bm25_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [bm25_pkg::CFG_DATA_W-1:0] cfg_data;

	bm25_in_if posting ();
	bm25_out_if score ();

	bm25_document_term_score_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .posting(posting.sink), .score(score.source)
	);

	// shadow registers
	logic [bm25_pkg::WT_W-1:0] sh_tw, sh_extra_num;
	logic [bm25_pkg::INV_W-1:0] sh_inv;
	logic [bm25_pkg::K1_W-1:0] sh_k1;
	logic [bm25_pkg::B_W-1:0] sh_b;
	logic [bm25_pkg::NL_W-1:0] sh_min_nl;

	score_t pending_scores[$];
	int errors;
	int hold_cycles;
	bit stall_on;
	localparam int LATENCY = 41;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic logic [23:0] normalised_len(input logic [23:0] len);
		logic [63:0] n;
		n = (64'(len) * 64'(sh_inv)) >> 8;
		if (n > 64'hFFFFFF) n = 64'hFFFFFF;
		if (n < 64'(sh_min_nl)) n = 64'(sh_min_nl);
		return n[23:0];
	endfunction

	function automatic score_t bm25_score(input logic act, input logic [23:0] wdf,
			input logic [23:0] len);
		score_t r;
		logic [23:0] plen, nl;
		logic [63:0] bb, inner, denom;
		logic [127:0] q;
		logic [bm25_pkg::COUNT_BITS_DEF-1:0] w, l;
		w = wdf;
		l = len;
		plen = (act && w > l) ? w : l;
		bb = (sh_b > bm25_pkg::UNITY) ? 64'h10000 : 64'(sh_b);
		nl = normalised_len(plen);
		inner = ((64'(nl) * bb) >> 16) + (64'h10000 - bb);
		denom = ((64'(sh_k1) * inner) >> 16) + (64'(w) << 16);
		if (denom == 0) r.part_weight = '0;
		else begin
			q = (128'(sh_tw) * (128'(w) << 16)) / 128'(denom);
			r.part_weight = (q > 128'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
		end
		nl = normalised_len(l);
		q = (128'(sh_extra_num) << 16) / (128'h10000 + 128'(nl));
		r.extra_weight = q[31:0];
		return r;
	endfunction

	task automatic write_reg(input bm25_pkg::cfg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			bm25_pkg::REG_TERM_WEIGHT: sh_tw = val;
			bm25_pkg::REG_INV_AVG: sh_inv = val;
			bm25_pkg::REG_K1: sh_k1 = val[23:0];
			bm25_pkg::REG_B: sh_b = val[16:0];
			bm25_pkg::REG_MIN_NL: sh_min_nl = val[23:0];
			bm25_pkg::REG_EXTRA_NUM: sh_extra_num = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// unknown index: ignored by the block
	task automatic write_bad_index();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= 3'd7;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_posting(input logic act, input logic [23:0] wdf,
			input logic [23:0] len);
		posting.valid <= 1'b1;
		posting.action <= act;
		posting.wdf <= wdf;
		posting.doc_len <= len;
		do @(posedge clk); while (!posting.ready);
		pending_scores.push_back(bm25_score(act, wdf, len));
	endtask

	task automatic idle_sender(input int n);
		posting.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		posting.valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_count();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(1, 2000));
		endcase
	endfunction

	task automatic random_burst(input int items);
		int left;
		int burst;
		left = items;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && left > 0) begin
				send_posting(1'($urandom_range(0, 1)), rand_count(), rand_count());
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
		end
	endtask

	// receiver
	always @(posedge clk) begin
		score_t got, want;
		if (score.valid && score.ready) begin
			got.part_weight = score.part_weight;
			got.extra_weight = score.extra_weight;
			if (pending_scores.size() == 0) report("score beat with nothing expected");
			else begin
				want = pending_scores.pop_front();
				if (got.part_weight !== want.part_weight)
					report($sformatf("part_weight %h, expected %h",
						got.part_weight, want.part_weight));
				if (got.extra_weight !== want.extra_weight)
					report($sformatf("extra_weight %h, expected %h",
						got.extra_weight, want.extra_weight));
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			score.ready <= 1'b0;
		end else if (stall_on)
			score.ready <= ($urandom_range(0, 3) != 0);
		else
			score.ready <= 1'b1;
	end

	task automatic test_defaults();
		send_posting(1'b0, 24'd0, 24'd0);
		send_posting(1'b0, 24'd1, 24'd1);
		send_posting(1'b0, 24'hFFFFFF, 24'hFFFFFF);
		send_posting(1'b1, 24'd100, 24'd3);
		send_posting(1'b1, 24'd3, 24'd100);
		send_posting(1'b0, 24'hAAAAAA, 24'h555555);
		send_posting(1'b0, 24'h555555, 24'hAAAAAA);
		drain();
	endtask

	task automatic test_extremes();
		write_reg(bm25_pkg::REG_TERM_WEIGHT, 32'hFFFFFFFF);
		write_reg(bm25_pkg::REG_INV_AVG, 32'hFFFFFFFF);
		write_reg(bm25_pkg::REG_K1, 32'h00FFFFFF);
		write_reg(bm25_pkg::REG_B, 32'h0001FFFF); // above one, used as one
		write_reg(bm25_pkg::REG_MIN_NL, 32'h00FFFFFF);
		write_reg(bm25_pkg::REG_EXTRA_NUM, 32'hFFFFFFFF);
		write_bad_index();
		send_posting(1'b0, 24'hFFFFFF, 24'hFFFFFF);
		send_posting(1'b1, 24'hFFFFFF, 24'd0);
		send_posting(1'b0, 24'd1, 24'd0);
		drain();
		// zero denominator
		write_reg(bm25_pkg::REG_K1, 32'd0);
		write_reg(bm25_pkg::REG_INV_AVG, 32'd0);
		write_reg(bm25_pkg::REG_MIN_NL, 32'd0);
		write_reg(bm25_pkg::REG_B, 32'd0);
		send_posting(1'b0, 24'd0, 24'd5);
		send_posting(1'b1, 24'd0, 24'hFFFFFF);
		send_posting(1'b0, 24'd7, 24'd0);
		drain();
	endtask

	task automatic random_config();
		write_reg(bm25_pkg::REG_TERM_WEIGHT, $urandom);
		write_reg(bm25_pkg::REG_INV_AVG,
			$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h2000000));
		write_reg(bm25_pkg::REG_K1, $urandom_range(0, 24'hFFFFFF));
		write_reg(bm25_pkg::REG_B, $urandom_range(0, 17'h1FFFF));
		write_reg(bm25_pkg::REG_MIN_NL, $urandom_range(0, 24'hFFFFFF));
		write_reg(bm25_pkg::REG_EXTRA_NUM, $urandom);
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			random_config();
			stall_on = (phase % 2 == 1);
			random_burst(110);
			drain();
		end
		stall_on = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_cycles = 150;
		random_burst(80);
		drain();
	endtask

	initial begin
		errors = 0;
		hold_cycles = 0;
		stall_on = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		posting.valid = 1'b0;
		posting.action = 1'b0;
		posting.wdf = '0;
		posting.doc_len = '0;
		score.ready = 1'b0;
		sh_tw = bm25_pkg::TERM_WEIGHT_RST;
		sh_inv = bm25_pkg::INV_AVG_RST;
		sh_k1 = bm25_pkg::K1_RST;
		sh_b = bm25_pkg::B_RST;
		sh_min_nl = bm25_pkg::MIN_NL_RST;
		sh_extra_num = bm25_pkg::EXTRA_NUM_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extremes();
		test_random();
		test_backpressure();
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/bm25_pkg.sv
hdl/bm25_in_if.sv
hdl/bm25_out_if.sv
hdl/bm25_document_term_score_top.sv
dv/bm25_document_term_score_top_test.sv
